// ===== hw/rtl/sgjs_pkg.sv =====
// Shared types and constants of the joint smoother.
// Used by sgjs_lane, sgjs_merge and the top level; depends on nothing.
package sgjs_pkg;

    localparam int NUM_TAPS  = 7;
    localparam int LANE_MAX  = 8;
    localparam int SLOT_W    = 3;
    localparam int TAP_W     = 16;
    localparam int NORM_W    = 24;
    localparam int JOINT_W   = 5;
    localparam int SERIAL_W  = 16;
    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int OUT_DEPTH = 16;
    localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LAST   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 4'd7;

    localparam logic signed [TAP_W-1:0] TAP_RESET [NUM_TAPS] =
        '{-16'sd2, 16'sd3, 16'sd6, 16'sd7, 16'sd6, 16'sd3, -16'sd2};
    localparam logic [NORM_W-1:0] NORM_RESET = 24'd798915;

    typedef struct packed {
        logic [JOINT_W-1:0]  joint;
        logic [SERIAL_W-1:0] serial;
    } meta_t;

    typedef struct packed {
        logic [POS_W-1:0]    z;
        logic [POS_W-1:0]    y;
        logic [POS_W-1:0]    x;
        logic [SERIAL_W-1:0] serial;
        logic [JOINT_W-1:0]  joint;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/sgjs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sgjs_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 25
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/sgjs_lane.sv =====
// One window lane: picks the stored or the incoming sample and weights x, y, z.
// Depends on sgjs_pkg.
module sgjs_lane
    import sgjs_pkg::*;
#(
    parameter int SW = 32
) (
    input  logic                       aclk,
    input  logic [3*SW-1:0]            ram_word,
    input  logic [3*SW-1:0]            bypass_word,
    input  logic                       use_bypass,
    input  logic signed [TAP_W-1:0]    tap,
    output logic signed [SW+TAP_W-1:0] prod_reg [3]
);
    logic [3*SW-1:0] word;

    assign word = use_bypass ? bypass_word : ram_word;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            prod_reg[c] <= $signed(word[c*SW +: SW]) * tap;
        end
    end
endmodule

// ===== hw/rtl/sgjs_merge.sv =====
// Merging stage: adder tree over the lane products, Q0.24 scaling, rounding
// and saturation. Depends on sgjs_pkg.
module sgjs_merge
    import sgjs_pkg::*;
#(
    parameter int WIN = 7,
    parameter int SW  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  meta_t                      in_meta,
    input  logic signed [SW+TAP_W-1:0] prod [WIN][3],
    input  logic [NORM_W-1:0]          norm_scale,
    output logic                       out_valid,
    output result_t                    out_result
);
    localparam int PW   = SW + TAP_W;
    localparam int SUMW = PW + 3;
    localparam int MW   = SUMW + 12;
    localparam int AW   = SUMW + 25;
    localparam int RW   = SUMW + 1;
    localparam logic [AW-1:0] ROUND   = AW'(24'h800000);
    localparam logic [RW-1:0] POS_MAX = (RW'(1) << (SW - 1)) - RW'(1);
    localparam logic [RW-1:0] NEG_MAX = RW'(1) << (SW - 1);

    logic signed [SUMW-1:0] pad [LANE_MAX][3];
    logic signed [SUMW-1:0] l1_reg [4][3];
    logic signed [SUMW-1:0] l2_reg [2][3];
    logic signed [SUMW-1:0] sum_reg [3];
    logic [SUMW-1:0]        mag_reg [3];
    logic [MW-1:0]          a_reg [3];
    logic [MW-1:0]          b_reg [3];
    logic [RW-1:0]          res_reg [3];
    logic [2:0]             neg4_reg, neg5_reg, neg6_reg;
    logic [6:0]             vld_reg;
    meta_t                  meta_reg [6];
    logic [AW-1:0]          acc [3];
    logic [RW-1:0]          sat [3];
    logic signed [SW-1:0]   val [3];
    logic [POS_W-1:0]       val32 [3];

    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            for (int c = 0; c < 3; c++) begin
                pad[i][c] = '0;
            end
        end
        for (int i = 0; i < WIN; i++) begin
            for (int c = 0; c < 3; c++) begin
                pad[i][c] = SUMW'(prod[i][c]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            acc[c] = AW'({b_reg[c], 12'h000}) + AW'(a_reg[c]) + ROUND;
            if (neg6_reg[c]) begin
                sat[c] = (res_reg[c] > NEG_MAX) ? NEG_MAX : res_reg[c];
                val[c] = -$signed(sat[c][SW-1:0]);
            end else begin
                sat[c] = (res_reg[c] > POS_MAX) ? POS_MAX : res_reg[c];
                val[c] = $signed(sat[c][SW-1:0]);
            end
            val32[c] = POS_W'(val[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
        meta_reg[0] <= in_meta;
        for (int s = 1; s < 6; s++) begin
            meta_reg[s] <= meta_reg[s-1];
        end
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 4; i++) begin
                l1_reg[i][c] <= pad[2*i][c] + pad[2*i+1][c];
            end
            l2_reg[0][c] <= l1_reg[0][c] + l1_reg[1][c];
            l2_reg[1][c] <= l1_reg[2][c] + l1_reg[3][c];
            sum_reg[c]   <= l2_reg[0][c] + l2_reg[1][c];
            neg4_reg[c]  <= sum_reg[c][SUMW-1];
            mag_reg[c]   <= sum_reg[c][SUMW-1] ? (~sum_reg[c] + SUMW'(1)) : sum_reg[c];
            neg5_reg[c]  <= neg4_reg[c];
            a_reg[c]     <= MW'(mag_reg[c]) * MW'(norm_scale[11:0]);
            b_reg[c]     <= MW'(mag_reg[c]) * MW'(norm_scale[23:12]);
            neg6_reg[c]  <= neg5_reg[c];
            res_reg[c]   <= acc[c][AW-1:24];
        end
        out_result.joint  <= meta_reg[5].joint;
        out_result.serial <= meta_reg[5].serial;
        out_result.x      <= val32[0];
        out_result.y      <= val32[1];
        out_result.z      <= val32[2];
    end

    assign out_valid = vld_reg[6];
endmodule

// ===== hw/rtl/sgjs_fifo.sv =====
// Result queue between the merging stage and the master channel.
// Depends on nothing.
module sgjs_fifo #(
    parameter int WIDTH = 117,
    parameter int DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = count_next + CNT_W'(1);
        end
        if (pop) begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
endmodule

// ===== hw/rtl/savitzky_golay_joint_smoother_unit.sv =====
// Top level of the per-joint Savitzky-Golay smoother: window control, lane RAMs,
// lanes, merging stage and result queue. Depends on sgjs_pkg, sgjs_ram,
// sgjs_lane, sgjs_merge and sgjs_fifo.
//
// Usage: one joint sample per s_ transaction (start flag on s_tuser). Each
// joint owns a circular window of 2*HALF_WINDOW+1 samples, one slot per lane
// RAM. Once a joint's window is full, a transaction leaves on m_ carrying the
// joint, the centre serial and the smoothed, saturated x, y, z.
// Throughput: one sample per cycle while s_tready is high; the window state
// is updated at the accepting edge and each lane RAM reads its slot at the
// same address, so a joint may follow itself in the next cycle.
// Path: an accepted sample passes the RAM read, lane multiply, three adder
// levels, magnitude, scaling, rounding and saturated-output registers into
// the output queue, where it is stored before it can be taken.
// Stall: s_tready drops only when 16 results are pending in the pipeline
// and the queue together; a stalled receiver never loses a result.
// Reset: fill counts and write slots return to zero, taps and norm_scale to
// their defaults; window contents are not cleared, no reset pass is needed.
// Configuration (cfg_*) is always ready; it must be written only while idle, which the user, not the block, ensures.
module savitzky_golay_joint_smoother_unit
    import sgjs_pkg::*;
#(
    parameter int NUM_JOINTS   = 25,
    parameter int HALF_WINDOW  = 3,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // joint_index, pos_x, pos_y, pos_z, frame_serial, zero pad
    input  logic [119:0]         s_tdata,
    // start_sequence
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_joint, center_serial, smooth_x, smooth_y, smooth_z, zero pad
    output logic [119:0]         m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NORM_W-1:0]    cfg_data
);
    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int AW     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int SW     = SAMPLE_WIDTH;
    localparam int PW     = SW + TAP_W;
    localparam int WORD_W = 3 * SW + SERIAL_W;
    localparam logic [SLOT_W-1:0] WIN_S    = SLOT_W'(WIN);
    localparam logic [SLOT_W-1:0] WIN_LAST = SLOT_W'(WIN - 1);

    logic [JOINT_W-1:0]  in_joint;
    logic [POS_W-1:0]    in_x, in_y, in_z;
    logic [SERIAL_W-1:0] in_serial;
    logic [6:0]          joint_ext;
    logic [AW-1:0]       addr;
    logic                in_range, accept, upd, emit, pop;
    logic [SLOT_W-1:0]   cur_slot, slot_next, fill_base, fill_next;
    logic [WORD_W-1:0]   word_in;

    logic [SLOT_W-1:0]        write_slot_reg [NUM_JOINTS];
    logic [SLOT_W-1:0]        fill_reg [NUM_JOINTS];
    logic signed [TAP_W-1:0]  tap_reg [NUM_TAPS];
    logic [NORM_W-1:0]        norm_reg;
    logic [PEND_W-1:0]        pending_reg, pending_next;

    logic [WORD_W-1:0]        ram_q [LANE_MAX];
    logic                     v1_reg, v2_reg;
    logic [JOINT_W-1:0]       joint1_reg;
    logic [SLOT_W-1:0]        slot1_reg;
    logic [3*SW-1:0]          bypass1_reg;
    meta_t                    meta2_reg;
    logic [SLOT_W-1:0]        ws_new1;
    logic [SLOT_W:0]          centre_sum;
    logic [SLOT_W-1:0]        centre_slot;
    logic [SLOT_W:0]          lane_dist [WIN];
    logic signed [TAP_W-1:0]  lane_tap [WIN];
    logic signed [PW-1:0]     prod [WIN][3];

    logic                     res_valid;
    result_t                  res_data;
    logic [RESULT_W-1:0]      fifo_q;

    assign in_joint  = s_tdata[4:0];
    assign in_x      = s_tdata[36:5];
    assign in_y      = s_tdata[68:37];
    assign in_z      = s_tdata[100:69];
    assign in_serial = s_tdata[116:101];
    assign joint_ext = {2'b00, in_joint};
    assign in_range  = (joint_ext < 7'(NUM_JOINTS));
    assign addr      = joint_ext[AW-1:0];
    assign accept    = s_tvalid & s_tready;
    assign upd       = accept & in_range;
    assign pop       = m_tvalid & m_tready;
    assign word_in   = {in_serial, in_z[SW-1:0], in_y[SW-1:0], in_x[SW-1:0]};

    always_comb begin
        cur_slot  = write_slot_reg[addr];
        slot_next = (cur_slot == WIN_LAST) ? '0 : cur_slot + SLOT_W'(1);
        fill_base = s_tuser ? '0 : fill_reg[addr];
        fill_next = (fill_base < WIN_S) ? fill_base + SLOT_W'(1) : fill_base;
        emit      = (fill_next == WIN_S);
    end

    always_comb begin
        pending_next = pending_reg;
        if (upd && emit) begin
            pending_next = pending_next + PEND_W'(1);
        end
        if (pop) begin
            pending_next = pending_next - PEND_W'(1);
        end
    end

    assign s_tready  = (pending_reg < PEND_W'(OUT_DEPTH));
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                write_slot_reg[j] <= '0;
                fill_reg[j]       <= '0;
            end
            for (int t = 0; t < NUM_TAPS; t++) begin
                tap_reg[t] <= TAP_RESET[t];
            end
            norm_reg    <= NORM_RESET;
            pending_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            if (upd) begin
                write_slot_reg[addr] <= slot_next;
                fill_reg[addr]       <= fill_next;
            end
            if (cfg_valid) begin
                if (cfg_index <= CFG_TAP_LAST) begin
                    tap_reg[cfg_index[SLOT_W-1:0]] <= cfg_data[TAP_W-1:0];
                end else if (cfg_index == CFG_NORM_SCALE) begin
                    norm_reg <= cfg_data;
                end
            end
            pending_reg <= pending_next;
            v1_reg      <= upd & emit;
            v2_reg      <= v1_reg;
        end
        joint1_reg  <= in_joint;
        slot1_reg   <= cur_slot;
        bypass1_reg <= word_in[3*SW-1:0];
        meta2_reg.joint  <= joint1_reg;
        meta2_reg.serial <= ram_q[centre_slot][WORD_W-1 -: SERIAL_W];
    end

    for (genvar s = 0; s < LANE_MAX; s++) begin : g_slot
        if (s < WIN) begin : g_ram
            sgjs_ram #(
                .WIDTH (WORD_W),
                .DEPTH (NUM_JOINTS)
            ) u_ram (
                .aclk  (aclk),
                .we    (upd && (cur_slot == SLOT_W'(s))),
                .waddr (addr),
                .wdata (word_in),
                .re    (accept),
                .raddr (addr),
                .rdata (ram_q[s])
            );
        end else begin : g_none
            assign ram_q[s] = '0;
        end
    end

    // The oldest sample sits in the slot after the one just written.
    always_comb begin
        ws_new1     = (slot1_reg == WIN_LAST) ? '0 : slot1_reg + SLOT_W'(1);
        centre_sum  = {1'b0, ws_new1} + (SLOT_W + 1)'(HALF_WINDOW);
        centre_slot = (centre_sum >= (SLOT_W + 1)'(WIN)) ?
                      SLOT_W'(centre_sum - (SLOT_W + 1)'(WIN)) : centre_sum[SLOT_W-1:0];
        for (int s = 0; s < WIN; s++) begin
            lane_dist[s] = (SLOT_W + 1)'(s + WIN) - {1'b0, ws_new1};
            if (lane_dist[s] >= (SLOT_W + 1)'(WIN)) begin
                lane_dist[s] = lane_dist[s] - (SLOT_W + 1)'(WIN);
            end
            lane_tap[s] = tap_reg[lane_dist[s][SLOT_W-1:0]];
        end
    end

    for (genvar s = 0; s < WIN; s++) begin : g_lane
        sgjs_lane #(
            .SW (SW)
        ) u_lane (
            .aclk        (aclk),
            .ram_word    (ram_q[s][3*SW-1:0]),
            .bypass_word (bypass1_reg),
            .use_bypass  (slot1_reg == SLOT_W'(s)),
            .tap         (lane_tap[s]),
            .prod_reg    (prod[s])
        );
    end

    sgjs_merge #(
        .WIN (WIN),
        .SW  (SW)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v2_reg),
        .in_meta    (meta2_reg),
        .prod       (prod),
        .norm_scale (norm_reg),
        .out_valid  (res_valid),
        .out_result (res_data)
    );

    sgjs_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_data  (fifo_q)
    );

    assign m_tdata = {3'b000, fifo_q};
endmodule

// ===== verif/savitzky_golay_joint_smoother_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of savitzky_golay_joint_smoother_unit: a directed table, then
// randomised joint streams across several tap and scale settings. Depends on sgjs_pkg.
module savitzky_golay_joint_smoother_unit_tb;
    import sgjs_pkg::*;

    localparam int JOINTS = 25;
    localparam int HALF   = 3;
    localparam int WIN    = 2 * HALF + 1;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 115;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_NORM_SCALE + CFG_IDX_W'(1);

    typedef struct {
        bit                  start;
        logic [JOINT_W-1:0]  joint;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [POS_W-1:0]    z;
        logic [SERIAL_W-1:0] serial;
        bit                  typed;
        result_t             want;
    } sample_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [119:0]         s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [119:0]         m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [NORM_W-1:0]    cfg_data;

    logic signed [POS_W-1:0] hist_pos [JOINTS][WIN][3];
    logic [SERIAL_W-1:0]     hist_serial [JOINTS][WIN];
    int unsigned             next_slot [JOINTS];
    int unsigned             fill_level [JOINTS];
    logic signed [TAP_W-1:0] weight [NUM_TAPS];
    logic [NORM_W-1:0]       norm_q24;

    result_t     pending_smoothed [$];
    sample_row_t directed_rows [$];
    int          fail_count;
    int          samples_sent;
    int          results_seen;
    int          reg_writes;
    bit          tx_steady;
    bit          rx_steady;

    always #2 aclk = ~aclk;

    savitzky_golay_joint_smoother_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic logic [POS_W-1:0] scale_round_sat(input longint acc);
        logic [63:0] mag, hi, lo, a, b, q, r, res;
        bit neg;
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        hi  = 64'(norm_q24 >> 12);
        lo  = 64'(norm_q24 & 24'hFFF);
        a   = mag * lo;
        b   = mag * hi;
        q   = b >> 12;
        r   = b & 64'hFFF;
        res = q + (((r << 12) + a + (64'd1 << 23)) >> 24);
        if (neg) begin
            if (res > (64'd1 << 31)) res = 64'd1 << 31;
            return POS_W'(64'd0 - res);
        end
        if (res > (64'd1 << 31) - 1) res = (64'd1 << 31) - 1;
        return POS_W'(res);
    endfunction

    function automatic bit smooth_step(input sample_row_t smp, output result_t res);
        int unsigned j, slot, s;
        longint acc;
        logic [POS_W-1:0] val [3];
        res = '0;
        j = smp.joint;
        if (j >= JOINTS) return 1'b0;
        if (smp.start) fill_level[j] = 0;
        slot = next_slot[j];
        hist_pos[j][slot][0] = smp.x;
        hist_pos[j][slot][1] = smp.y;
        hist_pos[j][slot][2] = smp.z;
        hist_serial[j][slot] = smp.serial;
        next_slot[j] = (slot + 1) % WIN;
        if (fill_level[j] < WIN) fill_level[j]++;
        if (fill_level[j] < WIN) return 1'b0;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < WIN; k++) begin
                s = (next_slot[j] + k) % WIN;
                acc += longint'(hist_pos[j][s][c]) * longint'(weight[k]);
            end
            val[c] = scale_round_sat(acc);
        end
        res.joint  = JOINT_W'(j);
        res.serial = hist_serial[j][(next_slot[j] + HALF) % WIN];
        res.x      = val[0];
        res.y      = val[1];
        res.z      = val[2];
        return 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [NORM_W-1:0] data);
        if (idx <= CFG_TAP_LAST) weight[idx[SLOT_W-1:0]] = data[TAP_W-1:0];
        else if (idx == CFG_NORM_SCALE) norm_q24 = data;
    endfunction

    function automatic sample_row_t row(input bit start, input logic [JOINT_W-1:0] joint,
                                        input logic [POS_W-1:0] x, y, z,
                                        input logic [SERIAL_W-1:0] serial,
                                        input bit typed, input result_t want);
        sample_row_t r;
        r.start  = start;
        r.joint  = joint;
        r.x      = x;
        r.y      = y;
        r.z      = z;
        r.serial = serial;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic void append_row(input sample_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return $urandom;
            default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        endcase
    endfunction

    task automatic send_sample(input sample_row_t smp);
        int unsigned gap;
        result_t res;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= smp.start;
        s_tdata  <= {3'b000, smp.serial, smp.z, smp.y, smp.x, smp.joint};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        if (smooth_step(smp, res))
            pending_smoothed = {pending_smoothed, (smp.typed ? smp.want : res)};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_smoothed.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic configure_phase(input int ph);
        logic signed [TAP_W-1:0] w;
        logic [NORM_W-1:0] nrm;
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 7)), NORM_W'($urandom));
        for (int k = 0; k < NUM_TAPS; k++) begin
            case (ph)
                0: w = 16'sh7FFF;
                1: w = -16'sh8000;
                2, 4: w = TAP_W'($urandom);
                3: w = TAP_W'($urandom_range(0, 128)) - 16'sd64;
                default: w = TAP_RESET[k];
            endcase
            write_reg(CFG_IDX_W'(k), {8'($urandom), w});
        end
        case (ph)
            0, 1: nrm = 24'hFF_FFFF;
            2: nrm = 24'h00_0000;
            5: nrm = NORM_RESET;
            default: nrm = NORM_W'($urandom);
        endcase
        write_reg(CFG_NORM_SCALE, nrm);
        cfg_valid <= 1'b0;
    endtask

    // receive side: draw a stall per transaction, then compare with the oldest prediction
    initial begin
        result_t got, want;
        int unsigned stall;
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready && aresetn));
            got = m_tdata[RESULT_W-1:0];
            results_seen++;
            if (pending_smoothed.size() == 0) begin
                $error("unexpected result: joint %0d serial %0h", got.joint, got.serial);
                fail_count++;
            end else begin
                want = pending_smoothed.pop_front();
                if (got.joint !== want.joint) begin
                    $error("out_joint: expected %0d got %0d", want.joint, got.joint);
                    fail_count++;
                end
                if (got.serial !== want.serial) begin
                    $error("center_serial: expected %0h got %0h", want.serial, got.serial);
                    fail_count++;
                end
                if (got.x !== want.x) begin
                    $error("smooth_x: expected %0h got %0h", want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $error("smooth_y: expected %0h got %0h", want.y, got.y);
                    fail_count++;
                end
                if (got.z !== want.z) begin
                    $error("smooth_z: expected %0h got %0h", want.z, got.z);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("savitzky_golay_joint_smoother_unit_tb: errors");
        $finish;
    end

    initial begin
        sample_row_t smp;
        int unsigned pick;
        logic [JOINT_W-1:0] group [4];
        fail_count   = 0;
        samples_sent = 0;
        results_seen = 0;
        reg_writes   = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        for (int j = 0; j < JOINTS; j++) begin
            next_slot[j]  = 0;
            fill_level[j] = 0;
            for (int s = 0; s < WIN; s++) begin
                hist_serial[j][s] = '0;
                for (int c = 0; c < 3; c++) hist_pos[j][s][c] = '0;
            end
        end
        for (int k = 0; k < NUM_TAPS; k++) weight[k] = TAP_RESET[k];
        norm_q24 = NORM_RESET;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out-of-range joints, a constant unit window with its known result, and full-scale windows
        append_row(row(1'b1, 5'd31, 32'h7FFF_FFFF, 32'h8000_0000, '1, 16'hFFFF,
                       1'b0, '0));
        for (int i = 0; i < WIN; i++)
            append_row(row(i == 0, 5'd0, 32'h0001_0000, 32'h0, 32'hFFFF_0000,
                           SERIAL_W'(i), i == WIN - 1,
                           {32'hFFFF_0000, 32'h0, 32'h0001_0000, 16'd3, 5'd0}));
        append_row(row(1'b0, 5'd25, 32'h1234_5678, 32'h0, 32'h0, 16'h0,
                       1'b0, '0));
        append_row(row(1'b0, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd7,
                       1'b0, '0));
        for (int i = 0; i < WIN; i++)
            append_row(row(i == 0, 5'd24, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                           16'hFFF9 + SERIAL_W'(i), i == WIN - 1,
                           {32'h0, 32'h8000_0080, 32'h7FFF_FF7F, 16'hFFFC,
                            5'd24}));
        append_row(row(1'b1, 5'd24, 32'h0000_8000, 32'hFFFF_8000, 32'h1,
                       16'h0, 1'b0, '0));
        append_row(row(1'b1, 5'd0, 32'h0000_3039, 32'h8000_0001, 32'h7FFF_FFFE,
                       16'h5555, 1'b0, '0));
        append_row(row(1'b0, 5'd24, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                       16'hAAAA, 1'b0, '0));
        append_row(row(1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0, '0));
        foreach (directed_rows[i]) send_sample(directed_rows[i]);
        drain_pipeline();

        for (int ph = 0; ph < PHASES; ph++) begin
            configure_phase(ph);
            tx_steady = (ph == 2) || (ph == 4);
            rx_steady = (ph == 2) || (ph == 5);
            for (int g = 0; g < 4; g++) group[g] = JOINT_W'($urandom_range(0, JOINTS - 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) smp.joint = JOINT_W'($urandom_range(JOINTS, 31));
                else if (pick < 15) smp.joint = JOINT_W'($urandom_range(0, JOINTS - 1));
                else smp.joint = group[$urandom_range(0, 3)];
                smp.start  = $urandom_range(0, 99) < 4;
                smp.x      = rand_pos();
                smp.y      = rand_pos();
                smp.z      = rand_pos();
                smp.serial = SERIAL_W'($urandom);
                smp.typed  = 1'b0;
                smp.want   = '0;
                send_sample(smp);
            end
            drain_pipeline();
        end

        $display("covered %0d samples, %0d smoothed results, %0d register writes",
                 samples_sent, results_seen, reg_writes);
        $display("phases: saturating taps, zero scale, random and default weights");
        if (fail_count == 0) begin
            $display("savitzky_golay_joint_smoother_unit_tb: clean");
        end else begin
            $display("savitzky_golay_joint_smoother_unit_tb: errors");
        end
        $finish;
    end

endmodule
